// ===== rtl/fp64_add_or_modq_lane_add_macros.svh =====
// Assertion macros used by the adder module.
`ifndef FP64_ADD_OR_MODQ_LANE_ADD_MACROS_SVH
`define FP64_ADD_OR_MODQ_LANE_ADD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define FPMQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpmq assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define FPMQ_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpmq assertion failed");

`endif

// ===== rtl/fpmq_pkg.sv =====
package fpmq_pkg;

  localparam logic [31:0] LANE_Q   = 32'd12289;
  localparam logic [10:0] EXP_ONES = 11'h7ff;
  localparam int unsigned LATENCY  = 6;

  // One pipeline stage register.
  typedef struct packed {
    logic        vld;
    logic        fin;
    logic        lane;
    logic [63:0] res;
    logic        sign;
    logic        sub;
    logic [11:0] e;
    logic [10:0] d;
    logic [62:0] mx;
    logic [61:0] my;
  } pipe_t;

  // Leading zeros of a nonzero 62-bit word, counted from the top bit.
  function automatic logic [5:0] lzc62(input logic [61:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 62; i++) begin
      if (v[i]) n = 6'(61 - i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/fp64_add_or_modq_lane_add.sv =====
// Shared adder: binary64 addition with round-to-nearest-even (mode 0), or
// two packed 32-bit lanes modulo 12289 (mode 1): the upper lane gives the
// sum mod q, the lower lane the difference mod q.
// An operand beat is taken at a rising edge where start is high and busy is
// low. busy stays low: the six-stage pipeline takes a new beat every cycle.
// Throughput is one beat per cycle. The result of a beat sits on result for
// exactly one cycle with done high, straight from the last stage register.
// Stages: special cases, operand swap and lane step one; alignment shift
// with sticky and lane add-back; mantissa add or subtract; zero check and
// leading-zero count; normalizing shift; rounding and packing.
// The receiver cannot stall, so nothing holds the pipeline back.
// Synchronous reset clears the stage valid bits; beats in flight are lost
// and done is low in the cycle after reset.
module fp64_add_or_modq_lane_add
  import fpmq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic [63:0] result,
  output logic        done
);

`include "fp64_add_or_modq_lane_add_macros.svh"

  pipe_t p1, p2, p3, p4, p5, p6;
  pipe_t p1_next, p2_next, p3_next, p4_next, p5_next, p6_next;

  assign busy = 1'b0;

  // Stage 1: special operands, swap by magnitude, lane first step.
  always_comb begin
    logic [10:0] ea, eb, exx, eyy, exa, eya;
    logic [63:0] x, y;
    p1_next     = '0;
    p1_next.vld = start;
    ea = op_a[62:52];
    eb = op_b[62:52];
    if (op_a[62:0] >= op_b[62:0]) begin
      x = op_a;
      y = op_b;
    end else begin
      x = op_b;
      y = op_a;
    end
    exx = x[62:52];
    eyy = y[62:52];
    exa = (exx == 11'd0) ? 11'd1 : exx;
    eya = (eyy == 11'd0) ? 11'd1 : eyy;
    p1_next.sign = x[63];
    p1_next.sub  = op_a[63] ^ op_b[63];
    p1_next.e    = {1'b0, exa};
    p1_next.d    = exa - eya;
    p1_next.mx   = {1'b0, (exx != 11'd0), x[51:0], 9'd0};
    p1_next.my   = {(eyy != 11'd0), y[51:0], 9'd0};
    if (mode) begin
      p1_next.lane = 1'b1;
      p1_next.res  = {op_a[63:32] + op_b[63:32] - LANE_Q, op_a[31:0] - op_b[31:0]};
    end else if (ea == EXP_ONES && eb == EXP_ONES) begin
      p1_next.fin = 1'b1;
      if (((op_a[51:0] | op_b[51:0]) == 52'd0)) begin
        p1_next.res = (op_a == op_b) ? op_a : '1;
      end else begin
        p1_next.res = (op_a > op_b) ? op_a : op_b;
      end
    end else if (ea == EXP_ONES) begin
      p1_next.fin = 1'b1;
      p1_next.res = op_a;
    end else if (eb == EXP_ONES) begin
      p1_next.fin = 1'b1;
      p1_next.res = op_b;
    end
  end

  // Stage 2: align the smaller mantissa, keep a sticky bit; lane add-back.
  always_comb begin
    logic [61:0] mask;
    p2_next = p1;
    mask    = ~({62{1'b1}} << p1.d[5:0]);
    if (p1.lane) begin
      p2_next.fin = 1'b1;
      if (p1.res[63]) p2_next.res[63:32] = p1.res[63:32] + LANE_Q;
      if (p1.res[31]) p2_next.res[31:0]  = p1.res[31:0] + LANE_Q;
    end else if (p1.d >= 11'd63) begin
      p2_next.my = {61'd0, (p1.my != 62'd0)};
    end else begin
      p2_next.my = (p1.my >> p1.d[5:0]) | {61'd0, ((p1.my & mask) != 62'd0)};
    end
  end

  // Stage 3: add or subtract the mantissas.
  always_comb begin
    p3_next = p2;
    if (p2.sub) p3_next.mx = p2.mx - {1'b0, p2.my};
    else        p3_next.mx = p2.mx + {1'b0, p2.my};
  end

  // Stage 4: zero sum, carry out, or leading-zero count for the left shift.
  always_comb begin
    logic [11:0] em1;
    logic [5:0]  lz;
    p4_next = p3;
    em1     = p3.e - 12'd1;
    lz      = lzc62(p3.mx[61:0]);
    p4_next.d = 11'd0;
    if (p3.fin) begin
      p4_next.d = 11'd0;
    end else if (p3.mx == 63'd0) begin
      p4_next.fin = 1'b1;
      p4_next.res = {(~p3.sub) & p3.sign, 63'd0};
    end else if (p3.mx[62]) begin
      p4_next.mx = {1'b0, p3.mx[62:2], p3.mx[1] | p3.mx[0]};
      p4_next.e  = p3.e + 12'd1;
    end else if (12'(lz) < em1) begin
      p4_next.d = {5'd0, lz};
    end else begin
      p4_next.d = {5'd0, em1[5:0]};
    end
  end

  // Stage 5: normalizing shift and overflow to infinity.
  always_comb begin
    p5_next    = p4;
    p5_next.mx = p4.mx << p4.d[5:0];
    p5_next.e  = p4.e - {6'd0, p4.d[5:0]};
    if (!p4.fin && p5_next.e >= {1'b0, EXP_ONES}) begin
      p5_next.fin = 1'b1;
      p5_next.res = {p4.sign, EXP_ONES, 52'd0};
    end
  end

  // Stage 6: round to nearest even and pack.
  always_comb begin
    logic [8:0]  r;
    logic [52:0] q;
    logic        up;
    logic [10:0] ef;
    p6_next = p5;
    r  = p5.mx[8:0];
    q  = p5.mx[61:9];
    up = (r > 9'd256) || (r == 9'd256 && q[0]);
    ef = p5.e[10:0] - 11'd1;
    if (!p5.fin) begin
      p6_next.res = {p5.sign, {ef, 52'd0} + {10'd0, q} + {62'd0, up}};
    end
  end

  // Stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1.vld <= 1'b0;
      p2.vld <= 1'b0;
      p3.vld <= 1'b0;
      p4.vld <= 1'b0;
      p5.vld <= 1'b0;
      p6.vld <= 1'b0;
    end else begin
      p1 <= p1_next;
      p2 <= p2_next;
      p3 <= p3_next;
      p4 <= p4_next;
      p5 <= p5_next;
      p6 <= p6_next;
    end
  end

  assign result = p6.res;
  assign done   = p6.vld;

  // A result beat always comes from a beat that was taken with start high.
  `FPMQ_ASSERT_IMP(a_done_src, clk, rst, done, $past(start, LATENCY))
  // Reset empties the pipeline.
  `FPMQ_ASSERT_NEXT(a_rst_empty, clk, rst, !done)
  // Equal lower lanes give a zero difference lane.
  `FPMQ_ASSERT_IMP(a_lane_zero, clk, rst,
    done && $past(mode && op_a[31:0] == op_b[31:0], LATENCY), result[31:0] == 32'd0)
  // A finite value plus its negation gives positive zero.
  `FPMQ_ASSERT_IMP(a_cancel, clk, rst,
    done && $past(!mode && op_a == {~op_b[63], op_b[62:0]} && op_a[62:52] != EXP_ONES, LATENCY),
    result == 64'd0)

endmodule
